[design/frr_pkg.sv]
// ----------------------------------------------------------------------------
// frr_pkg
// Shared widths, constants and tables for the rotated box pipeline.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam int COORD_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD         = 16;
  localparam int VW            = 40;
  localparam int AW            = 36;

  localparam int IN_W  = 96;
  localparam int OUT_W = 88;

  localparam logic [31:0] INVK_Q30 = 32'd652032874;
  localparam logic signed [AW-1:0] HALF_PI_Q30    = 36'sd1686629713;
  localparam logic signed [AW-1:0] QUARTER_PI_Q30 = 36'sd843314857;
  localparam logic signed [AW-1:0] PI_Q30         = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_Q30     = 36'sd6746518852;
  localparam int ANGLE_LIMIT = 25736;
  localparam int CENTER_MIN  = -131072;
  localparam int CENTER_MAX  = 131071;
  localparam int SIZE_MAX    = 131071;

  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [AW-1:0] ang_t;

  function automatic ang_t atan_q30(input int i);
    ang_t t;
    unique case (i)
      0:  t = 36'sd843314857;
      1:  t = 36'sd497837829;
      2:  t = 36'sd263043837;
      3:  t = 36'sd133525159;
      4:  t = 36'sd67021687;
      5:  t = 36'sd33543516;
      6:  t = 36'sd16775851;
      7:  t = 36'sd8388437;
      8:  t = 36'sd4194283;
      9:  t = 36'sd2097149;
      default: t = (i < 31) ? (ang_t'(1) <<< (30 - i)) : '0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic [COORD_BITS-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
  } pts_t;

endpackage

[design/frr_vec_stage.sv]
// ----------------------------------------------------------------------------
// frr_vec_stage
// One registered vectoring CORDIC iteration with angle accumulator.
// ----------------------------------------------------------------------------
module frr_vec_stage (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    shift,
  input  frr_pkg::vec_t x_i,
  input  frr_pkg::vec_t y_i,
  input  frr_pkg::ang_t z_i,
  output frr_pkg::vec_t x_r,
  output frr_pkg::vec_t y_r,
  output frr_pkg::ang_t z_r
);
  frr_pkg::vec_t xs, ys, x_nxt, y_nxt;
  frr_pkg::ang_t z_nxt;

  always_comb begin
    xs = x_i >>> shift;
    ys = y_i >>> shift;
    if (y_i < 0) begin
      x_nxt = x_i - ys; y_nxt = y_i + xs; z_nxt = z_i - frr_pkg::atan_q30(int'(shift));
    end else begin
      x_nxt = x_i + ys; y_nxt = y_i - xs; z_nxt = z_i + frr_pkg::atan_q30(int'(shift));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

[design/frr_rot_stage.sv]
// ----------------------------------------------------------------------------
// frr_rot_stage
// One registered rotation CORDIC iteration.
// ----------------------------------------------------------------------------
module frr_rot_stage (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    shift,
  input  frr_pkg::vec_t x_i,
  input  frr_pkg::vec_t y_i,
  input  frr_pkg::ang_t z_i,
  output frr_pkg::vec_t x_r,
  output frr_pkg::vec_t y_r,
  output frr_pkg::ang_t z_r
);
  frr_pkg::vec_t xs, ys, x_nxt, y_nxt;
  frr_pkg::ang_t z_nxt;

  always_comb begin
    xs = x_i >>> shift;
    ys = y_i >>> shift;
    if (z_i >= 0) begin
      x_nxt = x_i - ys; y_nxt = y_i + xs; z_nxt = z_i - frr_pkg::atan_q30(int'(shift));
    end else begin
      x_nxt = x_i + ys; y_nxt = y_i - xs; z_nxt = z_i + frr_pkg::atan_q30(int'(shift));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

[design/frr_gain.sv]
// ----------------------------------------------------------------------------
// frr_gain
// Two-stage CORDIC gain correction: split product, then sum.
// ----------------------------------------------------------------------------
module frr_gain (
  input  logic                      clk,
  input  logic                      en,
  input  logic [frr_pkg::VW-1:0]    v_i,
  output logic [frr_pkg::VW-1:0]    v_r
);
  logic [39:0] hi_r;
  logic [61:0] lo_r;
  logic [39:0] hi_nxt;
  logic [61:0] lo_nxt;

  always_comb begin
    hi_nxt = 40'(v_i[frr_pkg::VW-1:32]) * 40'(frr_pkg::INVK_Q30);
    lo_nxt = 62'(v_i[31:0]) * 62'(frr_pkg::INVK_Q30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
      v_r  <= frr_pkg::VW'({hi_r, 2'b00}) + frr_pkg::VW'(lo_r >> 30);
    end
  end
endmodule

[design/fiducial_rotated_rect_core.sv]
// ----------------------------------------------------------------------------
// fiducial_rotated_rect_core
// Rotated box from three marker points via pipelined CORDIC.
// ----------------------------------------------------------------------------
// channel | dir | width | contents
// in_     | in  | 96    | first, corner, third points (x,y each)
// out_    | out | 88    | center x/y, width, height, angle
// One transaction per cycle when the output is not stalled.
// Three CORDIC chains run in series (distance, diagonal, centre).
// Whole pipeline advances when the output register is free or being taken.
// rst_n clears only the valid bits.
module fiducial_rotated_rect_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // first_x, first_y, corner_x, corner_y, third_x, third_y
  input  logic [frr_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // center_x[17:0], center_y[35:18], box_width[52:36], box_height[69:53],
  // box_angle[85:70], zero fill
  output logic [frr_pkg::OUT_W-1:0]  out_tdata
);
  localparam int N   = frr_pkg::CORDIC_STAGES;
  localparam int LAT = 3 * N + 10;
  localparam int VW  = frr_pkg::VW;
  localparam int AW  = frr_pkg::AW;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end
  assign out_tvalid = vld_r[LAT-1];

  // stage 0: register inputs
  frr_pkg::pts_t pin_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pin_r.p0x <= in_tdata[15:0];
      pin_r.p0y <= in_tdata[31:16];
      pin_r.p1x <= in_tdata[47:32];
      pin_r.p1y <= in_tdata[63:48];
      pin_r.p2x <= in_tdata[79:64];
      pin_r.p2y <= in_tdata[95:80];
    end
  end

  function automatic frr_pkg::vec_t adiff(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = (a > b) ? a - b : b - a;
    return frr_pkg::vec_t'({d, 16'h0});
  endfunction

  // stage 1: differences and atan pre-rotation
  frr_pkg::vec_t a1x_r, a1y_r, a2x_r, a2y_r, tx_r, ty_r;
  frr_pkg::ang_t tz_r;
  logic tzero_r;
  logic [15:0] p0x1_r, p0y1_r;
  frr_pkg::vec_t ax, ay;
  always_comb begin
    ax = (frr_pkg::vec_t'($signed({1'b0, pin_r.p2x})) - frr_pkg::vec_t'($signed({1'b0, pin_r.p0x}))) <<< 16;
    ay = (frr_pkg::vec_t'($signed({1'b0, pin_r.p0y})) - frr_pkg::vec_t'($signed({1'b0, pin_r.p2y}))) <<< 16;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a1x_r <= adiff(pin_r.p0x, pin_r.p1x);
      a1y_r <= adiff(pin_r.p0y, pin_r.p1y);
      a2x_r <= adiff(pin_r.p2x, pin_r.p1x);
      a2y_r <= adiff(pin_r.p2y, pin_r.p1y);
      tzero_r <= (ax == 0) && (ay == 0);
      p0x1_r <= pin_r.p0x;
      p0y1_r <= pin_r.p0y;
      if (ax < 0 && ay >= 0) begin
        tx_r <= ay; ty_r <= -ax; tz_r <= frr_pkg::HALF_PI_Q30;
      end else if (ax < 0) begin
        tx_r <= -ay; ty_r <= ax; tz_r <= -frr_pkg::HALF_PI_Q30;
      end else begin
        tx_r <= ax; ty_r <= ay; tz_r <= '0;
      end
    end
  end

  // chain A: d1, d2, alpha in parallel (N stages)
  frr_pkg::vec_t m1x [N+1], m1y [N+1], m2x [N+1], m2y [N+1], tx [N+1], ty [N+1];
  frr_pkg::ang_t m1z [N+1], m2z [N+1], tz [N+1];
  logic [15:0] p0x_d [N+1], p0y_d [N+1];
  logic tzero_d [N+1];
  assign m1x[0] = a1x_r; assign m1y[0] = a1y_r; assign m1z[0] = '0;
  assign m2x[0] = a2x_r; assign m2y[0] = a2y_r; assign m2z[0] = '0;
  assign tx[0] = tx_r; assign ty[0] = ty_r; assign tz[0] = tz_r;
  assign p0x_d[0] = p0x1_r; assign p0y_d[0] = p0y1_r; assign tzero_d[0] = tzero_r;

  for (genvar i = 0; i < N; i++) begin : g_a
    frr_vec_stage u_m1 (.clk, .en, .shift(5'(i)), .x_i(m1x[i]), .y_i(m1y[i]), .z_i(m1z[i]),
      .x_r(m1x[i+1]), .y_r(m1y[i+1]), .z_r(m1z[i+1]));
    frr_vec_stage u_m2 (.clk, .en, .shift(5'(i)), .x_i(m2x[i]), .y_i(m2y[i]), .z_i(m2z[i]),
      .x_r(m2x[i+1]), .y_r(m2y[i+1]), .z_r(m2z[i+1]));
    frr_vec_stage u_at (.clk, .en, .shift(5'(i)), .x_i(tx[i]), .y_i(ty[i]), .z_i(tz[i]),
      .x_r(tx[i+1]), .y_r(ty[i+1]), .z_r(tz[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        p0x_d[i+1] <= p0x_d[i]; p0y_d[i+1] <= p0y_d[i]; tzero_d[i+1] <= tzero_d[i];
      end
    end
  end

  // gain on d1, d2 (2 stages)
  frr_pkg::vec_t d1, d2;
  frr_gain u_g1 (.clk, .en, .v_i(m1x[N]), .v_r(d1));
  frr_gain u_g2 (.clk, .en, .v_i(m2x[N]), .v_r(d2));
  frr_pkg::ang_t al_d [3];
  logic [15:0] p0x_g [3], p0y_g [3];
  assign al_d[0] = tzero_d[N] ? '0 : tz[N];
  assign p0x_g[0] = p0x_d[N]; assign p0y_g[0] = p0y_d[N];
  for (genvar i = 0; i < 2; i++) begin : g_g
    always_ff @(posedge clk) begin
      if (en) begin
        al_d[i+1] <= al_d[i]; p0x_g[i+1] <= p0x_g[i]; p0y_g[i+1] <= p0y_g[i];
      end
    end
  end

  // chain B: diagonal (N stages)
  frr_pkg::vec_t gx [N+1], gy [N+1];
  frr_pkg::ang_t gz [N+1];
  logic [16:0] w_d [N+1], h_d [N+1];
  frr_pkg::ang_t alb [N+1];
  logic [15:0] p0x_b [N+1], p0y_b [N+1];

  function automatic logic [16:0] size_out(input frr_pkg::vec_t d);
    logic [VW-17:0] v;
    v = d[VW-1:16];
    if (v > (VW-16)'(frr_pkg::SIZE_MAX)) v = (VW-16)'(frr_pkg::SIZE_MAX);
    return {v[16:4], 4'h0};
  endfunction

  assign gx[0] = d1; assign gy[0] = d2; assign gz[0] = '0;
  assign w_d[0] = size_out(d1); assign h_d[0] = size_out(d2);
  assign alb[0] = al_d[2]; assign p0x_b[0] = p0x_g[2]; assign p0y_b[0] = p0y_g[2];
  for (genvar i = 0; i < N; i++) begin : g_b
    frr_vec_stage u_dg (.clk, .en, .shift(5'(i)), .x_i(gx[i]), .y_i(gy[i]), .z_i(gz[i]),
      .x_r(gx[i+1]), .y_r(gy[i+1]), .z_r(gz[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        w_d[i+1] <= w_d[i]; h_d[i+1] <= h_d[i]; alb[i+1] <= alb[i];
        p0x_b[i+1] <= p0x_b[i]; p0y_b[i+1] <= p0y_b[i];
      end
    end
  end

  // diag gain, diag/2 gain (4 stages)
  frr_pkg::vec_t dg, r;
  frr_gain u_g3 (.clk, .en, .v_i(gx[N]), .v_r(dg));
  frr_gain u_g4 (.clk, .en, .v_i(dg >>> 1), .v_r(r));
  logic [16:0] w_e [5], h_e [5];
  frr_pkg::ang_t al_e [5];
  logic [15:0] p0x_e [5], p0y_e [5];
  assign w_e[0] = w_d[N]; assign h_e[0] = h_d[N]; assign al_e[0] = alb[N];
  assign p0x_e[0] = p0x_b[N]; assign p0y_e[0] = p0y_b[N];
  for (genvar i = 0; i < 4; i++) begin : g_e
    always_ff @(posedge clk) begin
      if (en) begin
        w_e[i+1] <= w_e[i]; h_e[i+1] <= h_e[i]; al_e[i+1] <= al_e[i];
        p0x_e[i+1] <= p0x_e[i]; p0y_e[i+1] <= p0y_e[i];
      end
    end
  end

  // chain C: centre rotation (pre-turn in one stage, then N stages)
  frr_pkg::vec_t cx [N+1], cy [N+1];
  frr_pkg::ang_t cz [N+1];
  frr_pkg::vec_t cx0_r, cy0_r;
  frr_pkg::ang_t cz0_r;
  logic [16:0] w_c [N+1], h_c [N+1];
  frr_pkg::ang_t alc [N+1];
  logic [15:0] p0x_c [N+1], p0y_c [N+1];
  always_ff @(posedge clk) begin
    if (en) begin
      w_c[0] <= w_e[4]; h_c[0] <= h_e[4]; alc[0] <= al_e[4];
      p0x_c[0] <= p0x_e[4]; p0y_c[0] <= p0y_e[4];
      if (al_e[4] > frr_pkg::HALF_PI_Q30) begin
        cx0_r <= '0; cy0_r <= r; cz0_r <= al_e[4] - frr_pkg::HALF_PI_Q30;
      end else if (al_e[4] < -frr_pkg::HALF_PI_Q30) begin
        cx0_r <= '0; cy0_r <= -r; cz0_r <= al_e[4] + frr_pkg::HALF_PI_Q30;
      end else begin
        cx0_r <= r; cy0_r <= '0; cz0_r <= al_e[4];
      end
    end
  end
  assign cx[0] = cx0_r; assign cy[0] = cy0_r; assign cz[0] = cz0_r;
  for (genvar i = 0; i < N; i++) begin : g_c
    frr_rot_stage u_rc (.clk, .en, .shift(5'(i)), .x_i(cx[i]), .y_i(cy[i]), .z_i(cz[i]),
      .x_r(cx[i+1]), .y_r(cy[i+1]), .z_r(cz[i+1]));
    always_ff @(posedge clk) begin
      if (en) begin
        w_c[i+1] <= w_c[i]; h_c[i+1] <= h_c[i]; alc[i+1] <= alc[i];
        p0x_c[i+1] <= p0x_c[i]; p0y_c[i+1] <= p0y_c[i];
      end
    end
  end

  // final: round, saturate, pack
  logic signed [VW:0] sx, sy, ex, ey;
  logic signed [AW:0] an, ar, aq;
  logic signed [17:0] ox, oy;
  logic signed [15:0] oa;
  always_comb begin
    sx = (VW+1)'($signed({1'b0, p0x_c[N], 16'h0})) + (VW+1)'(cx[N]) + (VW+1)'(33'sd32768);
    sy = (VW+1)'($signed({1'b0, p0y_c[N], 16'h0})) - (VW+1)'(cy[N]) + (VW+1)'(33'sd32768);
    ex = sx >>> 16;
    ey = sy >>> 16;
    ox = (ex > frr_pkg::CENTER_MAX) ? 18'(frr_pkg::CENTER_MAX) :
         (ex < frr_pkg::CENTER_MIN) ? 18'(frr_pkg::CENTER_MIN) : ex[17:0];
    oy = (ey > frr_pkg::CENTER_MAX) ? 18'(frr_pkg::CENTER_MAX) :
         (ey < frr_pkg::CENTER_MIN) ? 18'(frr_pkg::CENTER_MIN) : ey[17:0];
    an = (AW+1)'(alc[N]) - (AW+1)'(frr_pkg::QUARTER_PI_Q30);
    if (an < -(AW+1)'(frr_pkg::PI_Q30)) an = an + (AW+1)'(frr_pkg::TWO_PI_Q30);
    ar = an + (AW+1)'(65536);
    aq = ar >>> 17;
    oa = (aq > frr_pkg::ANGLE_LIMIT) ? 16'(frr_pkg::ANGLE_LIMIT) :
         (aq < -frr_pkg::ANGLE_LIMIT) ? 16'(-frr_pkg::ANGLE_LIMIT) : aq[15:0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {2'b00, oa, h_c[N], w_c[N], oy, ox};
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall lost");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");
  a_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[85:70]) <= 25736 && $signed(out_tdata[85:70]) >= -25736))
    else $error("angle range");
`endif
endmodule

[sim/tb_fiducial_rotated_rect_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fiducial_rotated_rect_core
// Drives marker point triples into the rotated box core and checks every
// centre, size and angle against a bit-exact CORDIC predictor, under varied
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_fiducial_rotated_rect_core;

  localparam int STAGES = 16;
  localparam int G      = 16;
  localparam int LAT    = 3 * STAGES + 10;
  localparam int WDOG   = 20000;

  typedef struct packed {
    logic [15:0] ang;
    logic [16:0] hgt;
    logic [16:0] wid;
    logic [17:0] cy;
    logic [17:0] cx;
  } box_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [87:0] out_tdata;

  box_t        box_q[$];
  int          mismatches;
  int          results_seen;
  int          items_sent;
  int          idle_cnt;
  int          send_gap_pct;
  int          recv_stall_pct;
  bit          done;

  fiducial_rotated_rect_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    return (i < 31) ? (longint'(1) << (30 - i)) : 0;
  endfunction

  function automatic longint scale_gain(longint v);
    longint unsigned u, hi, lo;
    u  = v;
    hi = u >> 32;
    lo = u & 64'hFFFF_FFFF;
    return ((hi * 652032874) << 2) + ((lo * 652032874) >> 30);
  endfunction

  function automatic longint vec_length(longint a, longint b);
    longint x, y, xs, ys;
    x = a;
    y = b;
    for (int i = 0; i < STAGES; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (y < 0) begin
        x -= ys; y += xs;
      end else begin
        x += ys; y -= xs;
      end
    end
    return scale_gain(x);
  endfunction

  function automatic longint bearing(longint yi, longint xi);
    longint x, y, z, t, xs, ys;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1686629713;
      end else begin
        t = x; x = -y; y = t; z = -1686629713;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (y < 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [16:0] whole_px(longint d);
    longint v;
    v = d >>> G;
    if (v > 131071) v = 131071;
    return 17'(v & ~longint'(15));
  endfunction

  function automatic box_t predict_box(logic [95:0] d);
    longint p0x, p0y, p1x, p1y, p2x, p2y, d1, d2, dg, alpha, ang;
    longint x, y, z, r, xs, ys, cx, cy;
    box_t b;
    p0x = d[15:0];  p0y = d[31:16]; p1x = d[47:32];
    p1y = d[63:48]; p2x = d[79:64]; p2y = d[95:80];
    d1 = vec_length((p0x > p1x ? p0x - p1x : p1x - p0x) << G,
                    (p0y > p1y ? p0y - p1y : p1y - p0y) << G);
    d2 = vec_length((p2x > p1x ? p2x - p1x : p1x - p2x) << G,
                    (p2y > p1y ? p2y - p1y : p1y - p2y) << G);
    dg = vec_length(d1, d2);
    alpha = bearing((p0y - p2y) << G, (p2x - p0x) << G);
    r = scale_gain(dg >> 1);
    x = r; y = 0; z = alpha;
    if (z > 1686629713) begin
      x = 0; y = r; z -= 1686629713;
    end else if (z < -1686629713) begin
      x = 0; y = -r; z += 1686629713;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = sra(x, i);
      ys = sra(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    cx = clampl(sra((p0x << G) + x + (1 << (G - 1)), G), -131072, 131071);
    cy = clampl(sra((p0y << G) - y + (1 << (G - 1)), G), -131072, 131071);
    ang = alpha - 843314857;
    if (ang < -64'sd3373259426) ang += 64'sd6746518852;
    ang = clampl(sra(ang + (1 << 16), 17), -25736, 25736);
    b.cx  = 18'(cx);
    b.cy  = 18'(cy);
    b.wid = whole_px(d1);
    b.hgt = whole_px(d2);
    b.ang = 16'(ang);
    return b;
  endfunction

  task automatic send_points(logic [95:0] d);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    box_q.push_back(predict_box(d));
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [95:0] pack_pts(int ax, int ay, int bx, int by, int cx, int cy);
    return {16'(cy), 16'(cx), 16'(by), 16'(bx), 16'(ay), 16'(ax)};
  endfunction

  function automatic logic [95:0] rand_marker();
    int cx, cy, s, ux, uy;
    cx = $urandom_range(65535);
    cy = $urandom_range(65535);
    s  = ($urandom_range(3) == 0) ? $urandom_range(20000) : $urandom_range(2000);
    ux = $urandom_range(2 * s) - s;
    uy = $urandom_range(2 * s) - s;
    return pack_pts(cx + ux, cy + uy, cx, cy, cx - uy, cy + ux);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (!(in_tvalid && in_tready) && !(out_tvalid && out_tready)) idle_cnt++;
      else idle_cnt = 0;
      if (idle_cnt >= WDOG) begin
        $display("Watchdog expired with %0d results pending", box_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    box_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = box_t'(out_tdata[85:0]);
      results_seen++;
      if (box_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_tdata);
      end else begin
        want = box_q.pop_front();
        if (got !== want || out_tdata[87:86] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch cx %h/%h cy %h/%h w %h/%h h %h/%h a %h/%h",
                     want.cx, got.cx, want.cy, got.cy, want.wid, got.wid,
                     want.hgt, got.hgt, want.ang, got.ang);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_directed();
    send_points(pack_pts(0, 0, 0, 0, 0, 0));
    send_points(pack_pts(65535, 65535, 65535, 65535, 65535, 65535));
    send_points(pack_pts(0, 0, 65535, 65535, 0, 0));
    send_points(pack_pts(65535, 0, 0, 65535, 0, 0));
    send_points(pack_pts(0, 65535, 65535, 0, 65535, 65535));
    send_points(pack_pts(0, 0, 65535, 0, 65535, 65535));
    send_points(pack_pts(65535, 65535, 0, 65535, 0, 0));
    send_points(pack_pts(65535, 0, 0, 0, 0, 65535));
    send_points(pack_pts(0, 65535, 65535, 65535, 65535, 0));
    send_points(pack_pts(100, 100, 200, 100, 200, 200));
    send_points(pack_pts(100, 100, 100, 200, 0, 200));
    send_points(pack_pts(200, 100, 100, 100, 100, 0));
    send_points(pack_pts(1000, 1000, 1001, 1000, 1000, 1001));
    send_points(pack_pts(500, 500, 800, 900, 500, 500));
    send_points(pack_pts(0, 32768, 32768, 65535, 65535, 32768));
    send_points(pack_pts(65535, 32768, 32768, 0, 0, 32768));
    send_points(pack_pts(0, 0, 0, 0, 65535, 1));
    send_points(pack_pts(0, 1, 0, 0, 65535, 0));
    send_points(pack_pts(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 7) send_points(rand_marker());
      else send_points({$urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    mismatches     = 0;
    results_seen   = 0;
    items_sent     = 0;
    idle_cnt       = 0;
    send_gap_pct   = 20;
    recv_stall_pct = 80;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(280);
    send_gap_pct   = 80;
    recv_stall_pct = 20;
    test_random(280);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(280);
    in_tvalid <= 1'b0;
    while (box_q.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("Sent %0d point sets, checked %0d boxes across three back-pressure mixes",
             items_sent, results_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
